>>> rtl/core/lobm_pkg.sv
package lobm_pkg;

  localparam int QTY_BITS  = 31;
  localparam int TIME_BITS = 32;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_RESTED   = 3'd0,
    ST_FILLED   = 3'd1,
    ST_DUP      = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_INACTIVE = 3'd4,
    ST_UNKNOWN  = 3'd5,
    ST_FULL     = 3'd6
  } status_t;

  // operation broadcast to every cell of one side
  typedef enum logic [3:0] {
    OP_NONE   = 4'b0001,
    OP_INSERT = 4'b0010,
    OP_POP    = 4'b0100,
    OP_DELETE = 4'b1000
  } cell_op_t;

endpackage

>>> rtl/core/lobm_if.sv
interface lobm_in_if #(
  parameter int ID_BITS = 12,
  parameter int PRICE_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [ID_BITS-1:0]    ord_id;
  logic                  side;
  logic [PRICE_BITS-1:0] price;
  logic [30:0]           quantity;
  logic [31:0]           timestamp;

  modport source (output valid, func, ord_id, side, price, quantity, timestamp,
                  input ready);
  modport sink (input valid, func, ord_id, side, price, quantity, timestamp,
                output ready);
endinterface

interface lobm_out_if #(
  parameter int PRICE_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            status;
  logic [30:0]           filled_qty;
  logic [30:0]           remaining_qty;
  logic [PRICE_BITS-1:0] top_bid;
  logic [PRICE_BITS-1:0] top_ask;
  logic [PRICE_BITS:0]   last_price_half;
  logic [30:0]           last_volume;

  modport source (output valid, status, filled_qty, remaining_qty, top_bid, top_ask,
                  last_price_half, last_volume, input ready);
  modport sink (input valid, status, filled_qty, remaining_qty, top_bid, top_ask,
                last_price_half, last_volume, output ready);
endinterface

>>> rtl/core/lobm_cell.sv
// one book entry; takes from its better or worse neighbor on insert and delete
module lobm_cell #(
  parameter int ID_BITS = 12,
  parameter int PRICE_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lobm_pkg::cell_op_t          op,
  input  logic                        is_ask,
  input  logic [PRICE_BITS-1:0]       new_price,
  input  logic [lobm_pkg::QTY_BITS-1:0]  new_qty,
  input  logic [ID_BITS-1:0]          new_id,
  input  logic [lobm_pkg::TIME_BITS-1:0] new_time,
  input  logic [ID_BITS-1:0]          del_id,
  // neighbor toward the top of book
  input  logic                        prev_valid,
  input  logic                        prev_goes_after,
  input  logic                        prev_hit,
  input  logic [PRICE_BITS-1:0]       prev_price,
  input  logic [lobm_pkg::QTY_BITS-1:0]  prev_qty,
  input  logic [ID_BITS-1:0]          prev_id,
  input  logic [lobm_pkg::TIME_BITS-1:0] prev_time,
  // neighbor toward the bottom
  input  logic                        next_valid,
  input  logic [PRICE_BITS-1:0]       next_price,
  input  logic [lobm_pkg::QTY_BITS-1:0]  next_qty,
  input  logic [ID_BITS-1:0]          next_id,
  input  logic [lobm_pkg::TIME_BITS-1:0] next_time,
  // quantity update for the head cell
  input  logic                        set_qty,
  input  logic [lobm_pkg::QTY_BITS-1:0]  set_qty_val,
  output logic                        valid,
  output logic                        goes_after,
  output logic                        hit,
  output logic [PRICE_BITS-1:0]       price,
  output logic [lobm_pkg::QTY_BITS-1:0]  qty,
  output logic [ID_BITS-1:0]          id,
  output logic [lobm_pkg::TIME_BITS-1:0] ts
);
  import lobm_pkg::*;

  logic valid_next;
  logic ins_here;
  logic shift_down;
  logic del_here;

  // new entry goes after this one when this one is not worse
  always_comb begin
    if (price == new_price) begin
      goes_after = valid && !(ts > new_time);
    end else if (is_ask) begin
      goes_after = valid && !(price > new_price);
    end else begin
      goes_after = valid && !(price < new_price);
    end
  end

  assign hit        = prev_hit || (valid && id == del_id);
  assign ins_here   = !goes_after && prev_goes_after;
  assign shift_down = !goes_after && !prev_goes_after;
  assign del_here   = hit;

  always_comb begin
    valid_next = valid;
    case (op)
      OP_INSERT: valid_next = ins_here ? 1'b1 : (shift_down ? prev_valid : valid);
      OP_POP:    valid_next = next_valid;
      OP_DELETE: valid_next = del_here ? next_valid : valid;
      default:   valid_next = valid;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_INSERT: begin
        if (ins_here) begin
          price <= new_price; qty <= new_qty; id <= new_id; ts <= new_time;
        end else if (shift_down) begin
          price <= prev_price; qty <= prev_qty; id <= prev_id; ts <= prev_time;
        end
      end
      OP_POP: begin
        price <= next_price; qty <= next_qty; id <= next_id; ts <= next_time;
      end
      OP_DELETE: begin
        if (del_here) begin
          price <= next_price; qty <= next_qty; id <= next_id; ts <= next_time;
        end
      end
      default: begin
        if (set_qty) begin
          qty <= set_qty_val;
        end
      end
    endcase
  end
endmodule

>>> rtl/core/lobm_side.sv
// one side of the book as a row of cells; head cell is the best entry
module lobm_side #(
  parameter int BOOK_DEPTH = 64,
  parameter int ID_BITS = 12,
  parameter int PRICE_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lobm_pkg::cell_op_t          op,
  input  logic                        is_ask,
  input  logic [PRICE_BITS-1:0]       new_price,
  input  logic [lobm_pkg::QTY_BITS-1:0]  new_qty,
  input  logic [ID_BITS-1:0]          new_id,
  input  logic [lobm_pkg::TIME_BITS-1:0] new_time,
  input  logic [ID_BITS-1:0]          del_id,
  input  logic                        set_qty,
  input  logic [lobm_pkg::QTY_BITS-1:0]  set_qty_val,
  output logic                        head_valid,
  output logic [PRICE_BITS-1:0]       head_price,
  output logic [lobm_pkg::QTY_BITS-1:0]  head_qty,
  output logic [ID_BITS-1:0]          head_id,
  output logic                        full,
  output logic                        found
);
  import lobm_pkg::*;

  logic                 v  [BOOK_DEPTH+1];
  logic                 ga [BOOK_DEPTH];
  logic                 ht [BOOK_DEPTH];
  logic [PRICE_BITS-1:0] p [BOOK_DEPTH+1];
  logic [QTY_BITS-1:0]  q  [BOOK_DEPTH+1];
  logic [ID_BITS-1:0]   d  [BOOK_DEPTH+1];
  logic [TIME_BITS-1:0] t  [BOOK_DEPTH+1];

  // boundary at the bottom: empty, carries nothing
  assign v[BOOK_DEPTH] = 1'b0;
  assign p[BOOK_DEPTH] = '0;
  assign q[BOOK_DEPTH] = '0;
  assign d[BOOK_DEPTH] = '0;
  assign t[BOOK_DEPTH] = '0;

  for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
    logic                 pv, pga, pht;
    logic [PRICE_BITS-1:0] pp;
    logic [QTY_BITS-1:0]  pq;
    logic [ID_BITS-1:0]   pd;
    logic [TIME_BITS-1:0] pt;
    if (i == 0) begin : g_top
      assign pv = 1'b0; assign pga = 1'b1; assign pht = 1'b0;
      assign pp = '0; assign pq = '0; assign pd = '0; assign pt = '0;
    end else begin : g_mid
      assign pv = v[i-1]; assign pga = ga[i-1]; assign pht = ht[i-1];
      assign pp = p[i-1]; assign pq = q[i-1]; assign pd = d[i-1]; assign pt = t[i-1];
    end
    lobm_cell #(.ID_BITS(ID_BITS), .PRICE_BITS(PRICE_BITS)) u_cell (
      .clk, .rst, .op, .is_ask, .new_price, .new_qty, .new_id, .new_time, .del_id,
      .prev_valid(pv), .prev_goes_after(pga), .prev_hit(pht),
      .prev_price(pp), .prev_qty(pq), .prev_id(pd), .prev_time(pt),
      .next_valid(v[i+1]), .next_price(p[i+1]), .next_qty(q[i+1]),
      .next_id(d[i+1]), .next_time(t[i+1]),
      .set_qty(set_qty && i == 0), .set_qty_val,
      .valid(v[i]), .goes_after(ga[i]), .hit(ht[i]),
      .price(p[i]), .qty(q[i]), .id(d[i]), .ts(t[i])
    );
  end

  assign head_valid = v[0];
  assign head_price = p[0];
  assign head_qty   = q[0];
  assign head_id    = d[0];
  assign full       = v[BOOK_DEPTH-1];
  assign found      = ht[BOOK_DEPTH-1];
endmodule

>>> rtl/core/limit_order_book_matcher.sv
// order: an add goes through lookup, then match, where it consumes the resting entries
//   one by one (one head cell popped or trimmed per cycle), then finish and out; a remove
//   or a duplicate add goes from lookup straight to finish and out
// flow: one item at a time; the next is taken only once the result has been loaded into the
//   output register, which waits while that register still holds an untaken result
// reset: rst (synchronous, active high) empties both sides and clears trade state;
//   the two id bitmaps are then swept clear, one id per cycle, during which no item is taken
module limit_order_book_matcher #(
  parameter int BOOK_DEPTH = 64,
  parameter int ID_BITS = 12,
  parameter int PRICE_BITS = 24
) (
  input logic clk,
  input logic rst,
  lobm_in_if.sink    in_ch,
  lobm_out_if.source out_ch
);
  import lobm_pkg::*;

  localparam int ID_COUNT = 1 << ID_BITS;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_LOOKUP = 6'b000100,
    S_MATCH  = 6'b001000,
    S_FINISH = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state, state_next;

  // id bitmaps in memory: bit 1 seen, bit 0 inactive
  logic [1:0]         marks [ID_COUNT];
  logic [1:0]         mark_rd;
  logic               mark_we;
  logic [ID_BITS-1:0] mark_wa;
  logic [1:0]         mark_wd;
  logic [ID_BITS:0]   clr_cnt;

  // captured item
  logic                  func;
  logic [ID_BITS-1:0]    oid;
  logic                  side;
  logic [PRICE_BITS-1:0] price;
  logic [QTY_BITS-1:0]   remaining;
  logic [QTY_BITS-1:0]   filled;
  logic [TIME_BITS-1:0]  ts;
  logic [PRICE_BITS-1:0] lastp;

  logic [PRICE_BITS-1:0] last_trade_price;
  logic [QTY_BITS-1:0]   last_trade_volume;

  // side control
  cell_op_t              bid_op, ask_op;
  logic                  bid_set, ask_set;
  logic [QTY_BITS-1:0]   set_val;
  logic                  bid_hv, ask_hv, bid_full, ask_full, bid_found, ask_found;
  logic [PRICE_BITS-1:0] bid_hp, ask_hp;
  logic [QTY_BITS-1:0]   bid_hq, ask_hq;
  logic [ID_BITS-1:0]    bid_hid, ask_hid;

  // opposite head as seen by the matcher
  logic                  opp_v;
  logic [PRICE_BITS-1:0] opp_p;
  logic [QTY_BITS-1:0]   opp_q;
  logic [ID_BITS-1:0]    opp_id;
  logic                  crosses;
  logic [QTY_BITS-1:0]   exec;
  logic                  own_full;

  // working result fields, then the output register
  logic                  res_valid;
  status_t               res_status;
  logic [QTY_BITS-1:0]   res_filled, res_rem;
  logic                  out_load;
  status_t               rsp_status;
  logic [QTY_BITS-1:0]   rsp_filled, rsp_rem, rsp_vol;
  logic [PRICE_BITS-1:0] rsp_bid, rsp_ask;
  logic [PRICE_BITS:0]   rsp_half;

  assign opp_v  = side ? bid_hv  : ask_hv;
  assign opp_p  = side ? bid_hp  : ask_hp;
  assign opp_q  = side ? bid_hq  : ask_hq;
  assign opp_id = side ? bid_hid : ask_hid;
  assign own_full = side ? ask_full : bid_full;
  assign crosses = opp_v && (side ? !(price > opp_p) == 1'b0 ? 1'b0 : 1'b1
                                  : !(price < opp_p));
  assign exec = (remaining < opp_q) ? remaining : opp_q;

  // output register is free or being emptied in this cycle
  assign out_load = (state == S_OUT) && (!res_valid || out_ch.ready);

  assign in_ch.ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    bid_op = OP_NONE; ask_op = OP_NONE;
    bid_set = 1'b0; ask_set = 1'b0;
    set_val = opp_q - exec;
    mark_we = 1'b0; mark_wa = oid; mark_wd = mark_rd;
    case (state)
      S_CLEAR: begin
        mark_we = 1'b1;
        mark_wa = clr_cnt[ID_BITS-1:0];
        mark_wd = 2'b00;
        if (clr_cnt == (ID_BITS+1)'(ID_COUNT - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (func == FUNC_REMOVE) begin
          bid_op = OP_DELETE; ask_op = OP_DELETE;
          state_next = S_FINISH;
        end else if (mark_rd[1]) begin
          state_next = S_FINISH;
        end else begin
          mark_we = 1'b1; mark_wd = {1'b1, mark_rd[0]};
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        if (remaining != '0 && crosses) begin
          if (exec == opp_q) begin
            mark_we = 1'b1; mark_wa = opp_id; mark_wd = 2'b11;
            if (side) bid_op = OP_POP; else ask_op = OP_POP;
          end else begin
            if (side) bid_set = 1'b1; else ask_set = 1'b1;
          end
        end else begin
          if (remaining == '0 || own_full) begin
            mark_we = 1'b1; mark_wd = 2'b11;
          end else if (side) begin
            ask_op = OP_INSERT;
          end else begin
            bid_op = OP_INSERT;
          end
          state_next = S_FINISH;
        end
      end
      S_FINISH: state_next = S_OUT;
      S_OUT: begin
        // waits here while the previous result is still untaken
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // remove marks the id inactive when something was deleted; the delete happens in
  // the lookup cycle, so the found flags are sampled there into found_any
  logic found_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      res_valid <= 1'b0;
      last_trade_price <= '0;
      last_trade_volume <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (out_load) res_valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) res_valid <= 1'b0;
      if (state == S_MATCH && !(remaining != '0 && crosses) && filled != '0) begin
        last_trade_price <= lastp;
        last_trade_volume <= filled;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mark_we || (state == S_FINISH && func == FUNC_REMOVE && found_any)) begin
      marks[mark_we ? mark_wa : oid] <= mark_we ? mark_wd : 2'b11;
    end
    mark_rd <= marks[(state == S_IDLE) ? in_ch.ord_id : oid];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_ch.valid && in_ch.ready) begin
      func <= in_ch.func; oid <= in_ch.ord_id; side <= in_ch.side;
      price <= in_ch.price; remaining <= in_ch.quantity; ts <= in_ch.timestamp;
      filled <= '0; lastp <= '0;
    end
    if (state == S_LOOKUP) found_any <= bid_found || ask_found;
    if (state == S_MATCH && remaining != '0 && crosses) begin
      remaining <= remaining - exec;
      filled <= filled + exec;
      lastp <= opp_p;
    end
    if (state == S_MATCH && !(remaining != '0 && crosses)) begin
      res_filled <= filled;
      res_rem <= remaining;
      if (remaining == '0) res_status <= ST_FILLED;
      else if (own_full) res_status <= ST_FULL;
      else res_status <= ST_RESTED;
    end
    if (state == S_FINISH && func == FUNC_REMOVE) begin
      res_filled <= '0; res_rem <= '0;
      if (found_any) res_status <= ST_REMOVED;
      else if (mark_rd != 2'b00) res_status <= ST_INACTIVE;
      else res_status <= ST_UNKNOWN;
    end
    if (state == S_LOOKUP && func == FUNC_ADD && mark_rd[1]) begin
      res_status <= ST_DUP; res_filled <= '0; res_rem <= remaining;
    end
  end

  lobm_side #(.BOOK_DEPTH(BOOK_DEPTH), .ID_BITS(ID_BITS), .PRICE_BITS(PRICE_BITS)) u_bid (
    .clk, .rst, .op(bid_op), .is_ask(1'b0), .new_price(price), .new_qty(remaining),
    .new_id(oid), .new_time(ts), .del_id(oid), .set_qty(bid_set), .set_qty_val(set_val),
    .head_valid(bid_hv), .head_price(bid_hp), .head_qty(bid_hq), .head_id(bid_hid),
    .full(bid_full), .found(bid_found)
  );

  lobm_side #(.BOOK_DEPTH(BOOK_DEPTH), .ID_BITS(ID_BITS), .PRICE_BITS(PRICE_BITS)) u_ask (
    .clk, .rst, .op(ask_op), .is_ask(1'b1), .new_price(price), .new_qty(remaining),
    .new_id(oid), .new_time(ts), .del_id(oid), .set_qty(ask_set), .set_qty_val(set_val),
    .head_valid(ask_hv), .head_price(ask_hp), .head_qty(ask_hq), .head_id(ask_hid),
    .full(ask_full), .found(ask_found)
  );

  // book summary, taken into the output register once the item has settled
  logic [PRICE_BITS-1:0] bb, ba;
  logic [PRICE_BITS:0]   half;
  assign bb = bid_hv ? bid_hp : '0;
  assign ba = ask_hv ? ask_hp : '0;
  assign half = (last_trade_price != '0) ? {last_trade_price, 1'b0}
      : (bb != '0 && ba != '0) ? ({1'b0, bb} + {1'b0, ba}) : '0;

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp_status <= res_status;
      rsp_filled <= res_filled;
      rsp_rem    <= res_rem;
      rsp_bid    <= bb;
      rsp_ask    <= ba;
      rsp_half   <= half;
      rsp_vol    <= last_trade_volume;
    end
  end

  assign out_ch.valid = res_valid;
  assign out_ch.status = rsp_status;
  assign out_ch.filled_qty = rsp_filled;
  assign out_ch.remaining_qty = rsp_rem;
  assign out_ch.top_bid = rsp_bid;
  assign out_ch.top_ask = rsp_ask;
  assign out_ch.last_price_half = rsp_half;
  assign out_ch.last_volume = rsp_vol;

`ifndef SYNTH
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ch.ready) else $error("input taken while busy");
  a_result_after_out: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |=> res_valid) else $error("result not raised");
  a_single_op: assert property (@(posedge clk) disable iff (rst)
    !(bid_op != OP_NONE && ask_op != OP_NONE && state != S_LOOKUP))
    else $error("both sides changed outside remove");
`endif
endmodule
